>>> design/chd_pkg.sv
// Shared types and constants for the chunked transfer decoder.
package chd_pkg;

   localparam int SIZE_BITS      = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef enum logic [1:0] {
      CLS_HEX,
      CLS_TERM,
      CLS_LF,
      CLS_OTHER
   } byte_class_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_FINISHED = 2'd1,
      KIND_ERROR    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_SIZE,
      PH_EXT,
      PH_DATA,
      PH_TAIL,
      PH_ERR
   } phase_type;

   typedef struct packed {
      byte_class_type cls;
      logic [3:0]     digit;
      logic [7:0]     data;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

endpackage

>>> design/chd_front.sv
// Front end: accepts raw request bytes and classifies them for the parser.
module chd_front
   import chd_pkg::*;
(
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       push_valid,
   input  logic       push_ready,
   output item_type   push_data
);

   logic [7:0] b;

   assign b          = req_tdata;
   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_data.data  = b;
      push_data.digit = b[3:0];
      push_data.cls   = CLS_OTHER;
      if (b >= 8'h30 && b <= 8'h39) begin
         push_data.cls = CLS_HEX;
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         push_data.cls   = CLS_HEX;
         push_data.digit = b[3:0] + 4'd9;
      end else if (b == CHAR_SPACE || b == CHAR_CR || b == CHAR_SEMI) begin
         push_data.cls = CLS_TERM;
      end else if (b == CHAR_LF) begin
         push_data.cls = CLS_LF;
      end
   end

endmodule

>>> design/chd_fifo.sv
// Short queue of classified bytes between front end and parser.
module chd_fifo
   import chd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_data
);

   item_type                  queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign push_ready = (count_ff != (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = queue_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/chd_back.sv
// Back end: chunk parser state machine and response output register.
module chd_back
   import chd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  item_type   pop_data,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic       rsp_tlast,   // chunk_end
   output logic [1:0] rsp_tuser    // [1:0] kind
);

   phase_type              phase_ff, phase_in;
   logic [SIZE_BITS-1:0]   chunk_size_ff, chunk_size_in;
   logic [SIZE_BITS-1:0]   bytes_left_ff, bytes_left_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;
   logic                   take, emit, overflow;
   result_type             result;

   assign pop_ready = !rsp_valid_ff || rsp_tready;
   assign take      = pop_valid && pop_ready;
   assign overflow  = (chunk_size_ff[SIZE_BITS-1 -: 4] != 4'd0);

   // next state
   always_comb begin
      phase_in      = phase_ff;
      chunk_size_in = chunk_size_ff;
      bytes_left_in = bytes_left_ff;
      if (take) begin
         case (phase_ff)
            PH_SIZE: begin
               case (pop_data.cls)
                  CLS_HEX: begin
                     if (overflow) begin
                        phase_in = PH_ERR;
                     end else begin
                        chunk_size_in = {chunk_size_ff[SIZE_BITS-5:0], pop_data.digit};
                     end
                  end
                  CLS_TERM: begin
                     bytes_left_in = '0;
                     phase_in      = PH_EXT;
                  end
                  default: phase_in = PH_ERR;
               endcase
            end
            PH_EXT: begin
               if (pop_data.cls == CLS_LF) begin
                  if (chunk_size_ff != '0) begin
                     bytes_left_in = chunk_size_ff;
                     phase_in      = PH_DATA;
                  end else begin
                     phase_in = PH_TAIL;
                  end
               end
            end
            PH_DATA: begin
               bytes_left_in = bytes_left_ff - 1'b1;
               if (bytes_left_ff == SIZE_BITS'(1)) begin
                  phase_in = PH_TAIL;
               end
            end
            PH_TAIL: begin
               if (pop_data.cls == CLS_LF) begin
                  chunk_size_in = '0;
                  bytes_left_in = '0;
                  phase_in      = PH_SIZE;
               end
            end
            default: phase_in = PH_ERR;
         endcase
      end
   end

   // outputs
   always_comb begin
      emit        = 1'b0;
      result.kind = KIND_PAYLOAD;
      result.data = 8'd0;
      result.last = 1'b0;
      case (phase_ff)
         PH_SIZE: begin
            if ((pop_data.cls == CLS_HEX && overflow) ||
                pop_data.cls == CLS_LF || pop_data.cls == CLS_OTHER) begin
               emit        = 1'b1;
               result.kind = KIND_ERROR;
            end
         end
         PH_DATA: begin
            emit        = 1'b1;
            result.data = pop_data.data;
            result.last = (bytes_left_ff == SIZE_BITS'(1));
         end
         PH_TAIL: begin
            if (pop_data.cls == CLS_LF && chunk_size_ff == '0) begin
               emit        = 1'b1;
               result.kind = KIND_FINISHED;
            end
         end
         default: emit = 1'b0;
      endcase
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = emit;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         chunk_size_ff <= '0;
         bytes_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         chunk_size_ff <= chunk_size_in;
         bytes_left_ff <= bytes_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.data;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tuser  = rsp_ff.kind;

endmodule

>>> design/http_chunked_decoder_core.sv
// Top level of the HTTP chunked transfer decoder.
// An accepted byte passes through the queue, then the response output register.
// Throughput: one byte per cycle unless rsp_tready stalls, set by the back-end parser update.
// A four-entry queue decouples the byte classifier from the parser.
// Synchronous reset returns the parser to size parsing and clears the queue,
// the chunk size, the byte count and a sticky protocol error.
module http_chunked_decoder_core
   import chd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic       rsp_tlast,   // chunk_end
   output logic [1:0] rsp_tuser    // [1:0] kind
);

   logic     push_valid, push_ready;
   item_type push_data;
   logic     pop_valid, pop_ready;
   item_type pop_data;

   chd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   chd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   chd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
